[rtl/sai_pkg.sv]
// Shared types, constants and sequencer states for the shift array block.
package sai_pkg;

	localparam int ENTRIES = 8;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DW      = 32;

	typedef logic [AW-1:0] addr_t;
	typedef logic [DW-1:0] data_t;

	localparam addr_t LAST = addr_t'(ENTRIES - 1);

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REVERSE = 2'd2,
		OP_SEARCH  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FLUSH,
		ST_FINAL,
		ST_SRCH,
		ST_SRCH_LAST,
		ST_REV_RD_LO,
		ST_REV_RD_HI,
		ST_REV_WR_LO,
		ST_REV_WR_HI,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [2:0] match_index;
	} res_t;

	typedef struct packed {
		addr_t nxt;
		addr_t adj;
		logic  at_end;
		logic  eq;
	} step_t;

endpackage

[rtl/sai_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sai_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/sai_step.sv]
// Shared index step and key compare unit used by every sequencer walk.
module sai_step (
	input  sai_pkg::addr_t idx,
	input  logic           dec,
	input  sai_pkg::addr_t end_idx,
	input  sai_pkg::data_t key,
	input  sai_pkg::data_t data,
	output sai_pkg::step_t step
);

	always_comb begin
		step.nxt    = dec ? sai_pkg::addr_t'(idx - 1'b1) : sai_pkg::addr_t'(idx + 1'b1);
		step.adj    = dec ? sai_pkg::addr_t'(idx + 1'b1) : sai_pkg::addr_t'(idx - 1'b1);
		step.at_end = (idx == end_idx);
		step.eq     = (data == key);
	end

endmodule

[rtl/sai_engine.sv]
// Sequencer that walks the entry RAM for insert, delete, reverse and search.
module sai_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sai_pkg::req_t req,
	input  logic          res_ready,
	output logic          idle,
	output logic          res_valid,
	output sai_pkg::res_t res
);

	sai_pkg::state_t state_q, state_d;

	sai_pkg::addr_t idx_q, hi_q, wa_q, end_q, fin_addr_q, fidx_q;
	sai_pkg::data_t fin_data_q, key_q, tmp_q;
	logic           dec_q, pend_q, found_q, rvalid_q;
	logic [sai_pkg::ENTRIES-1:0] valid_q;

	logic           ram_we;
	sai_pkg::addr_t ram_waddr, ram_raddr;
	sai_pkg::data_t ram_wdata, ram_rdata, rdata_eff;
	sai_pkg::step_t step;

	logic           past_end, ins_direct, rev_more;
	sai_pkg::addr_t pos_a;

	assign pos_a      = sai_pkg::addr_t'(req.position);
	assign past_end   = 32'(req.position) >= 32'(sai_pkg::ENTRIES);
	assign ins_direct = past_end || (pos_a == sai_pkg::LAST);
	assign rdata_eff  = rvalid_q ? ram_rdata : '0;
	assign rev_more   = 32'(sai_pkg::addr_t'(hi_q - idx_q)) > 32'd2;

	sai_step u_step (
		.idx     (idx_q),
		.dec     (dec_q),
		.end_idx (end_q),
		.key     (key_q),
		.data    (rdata_eff),
		.step    (step)
	);

	sai_ram #(
		.WIDTH (sai_pkg::DW),
		.DEPTH (sai_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sai_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.op)
						sai_pkg::OP_INSERT:  state_d = ins_direct ? sai_pkg::ST_FINAL : sai_pkg::ST_SHIFT;
						sai_pkg::OP_DELETE: begin
							if (past_end) state_d = sai_pkg::ST_DONE;
							else if (pos_a == sai_pkg::LAST) state_d = sai_pkg::ST_FINAL;
							else state_d = sai_pkg::ST_SHIFT;
						end
						sai_pkg::OP_REVERSE: state_d = sai_pkg::ST_REV_RD_LO;
						sai_pkg::OP_SEARCH:  state_d = sai_pkg::ST_SRCH;
						default:             state_d = sai_pkg::ST_IDLE;
					endcase
				end
			end
			sai_pkg::ST_SHIFT:     if (step.at_end) state_d = sai_pkg::ST_FLUSH;
			sai_pkg::ST_FLUSH:     state_d = sai_pkg::ST_FINAL;
			sai_pkg::ST_FINAL:     state_d = sai_pkg::ST_DONE;
			sai_pkg::ST_SRCH: begin
				if (pend_q && step.eq) state_d = sai_pkg::ST_DONE;
				else if (step.at_end) state_d = sai_pkg::ST_SRCH_LAST;
			end
			sai_pkg::ST_SRCH_LAST: state_d = sai_pkg::ST_DONE;
			sai_pkg::ST_REV_RD_LO: state_d = sai_pkg::ST_REV_RD_HI;
			sai_pkg::ST_REV_RD_HI: state_d = sai_pkg::ST_REV_WR_LO;
			sai_pkg::ST_REV_WR_LO: state_d = sai_pkg::ST_REV_WR_HI;
			sai_pkg::ST_REV_WR_HI: state_d = rev_more ? sai_pkg::ST_REV_RD_LO : sai_pkg::ST_DONE;
			sai_pkg::ST_DONE:      if (res_ready) state_d = sai_pkg::ST_IDLE;
			default:               state_d = sai_pkg::ST_IDLE;
		endcase
	end

	// RAM port and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = rdata_eff;
		ram_raddr = idx_q;
		res_valid = 1'b0;
		idle      = 1'b0;
		unique case (state_q)
			sai_pkg::ST_IDLE:  idle = 1'b1;
			sai_pkg::ST_SHIFT: ram_we = pend_q;
			sai_pkg::ST_FLUSH: ram_we = 1'b1;
			sai_pkg::ST_FINAL: begin
				ram_we    = 1'b1;
				ram_waddr = fin_addr_q;
				ram_wdata = fin_data_q;
			end
			sai_pkg::ST_REV_RD_HI: ram_raddr = hi_q;
			sai_pkg::ST_REV_WR_LO: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
			end
			sai_pkg::ST_REV_WR_HI: begin
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = tmp_q;
			end
			sai_pkg::ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.found       = found_q;
	assign res.match_index = 3'(fidx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sai_pkg::ST_IDLE;
			valid_q  <= '0;
			rvalid_q <= 1'b0;
			pend_q   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				sai_pkg::ST_IDLE: begin
					pend_q  <= 1'b0;
					found_q <= 1'b0;
					fidx_q  <= '0;
					key_q   <= sai_pkg::data_t'(req.value);
					if (start) begin
						unique case (req.op)
							sai_pkg::OP_INSERT: begin
								idx_q      <= sai_pkg::addr_t'(sai_pkg::LAST - 1'b1);
								end_q      <= pos_a;
								dec_q      <= 1'b1;
								fin_addr_q <= past_end ? sai_pkg::LAST : pos_a;
								fin_data_q <= sai_pkg::data_t'(req.value);
							end
							sai_pkg::OP_DELETE: begin
								idx_q      <= sai_pkg::addr_t'(pos_a + 1'b1);
								end_q      <= sai_pkg::LAST;
								dec_q      <= 1'b0;
								fin_addr_q <= sai_pkg::LAST;
								fin_data_q <= '0;
							end
							sai_pkg::OP_REVERSE: begin
								idx_q <= '0;
								hi_q  <= sai_pkg::LAST;
								dec_q <= 1'b0;
							end
							sai_pkg::OP_SEARCH: begin
								idx_q <= '0;
								end_q <= sai_pkg::LAST;
								dec_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				sai_pkg::ST_SHIFT: begin
					pend_q <= 1'b1;
					wa_q   <= step.adj;
					if (!step.at_end) idx_q <= step.nxt;
				end
				sai_pkg::ST_SRCH: begin
					pend_q <= 1'b1;
					wa_q   <= idx_q;
					if (pend_q && step.eq) begin
						found_q <= 1'b1;
						fidx_q  <= wa_q;
					end else if (!step.at_end) begin
						idx_q <= step.nxt;
					end
				end
				sai_pkg::ST_SRCH_LAST: begin
					if (step.eq) begin
						found_q <= 1'b1;
						fidx_q  <= wa_q;
					end
				end
				sai_pkg::ST_REV_RD_HI: tmp_q <= rdata_eff;
				sai_pkg::ST_REV_WR_HI: begin
					idx_q <= step.nxt;
					hi_q  <= sai_pkg::addr_t'(hi_q - 1'b1);
				end
				default: ;
			endcase
		end
	end

	a_shift_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sai_pkg::ST_SHIFT) && ram_we |-> ram_waddr != ram_raddr)
		else $error("shift writes the slot it reads");

	a_rev_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sai_pkg::ST_REV_RD_LO) || (state_q == sai_pkg::ST_REV_WR_HI)
		|-> hi_q > idx_q)
		else $error("reverse pointers crossed");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sai_pkg::ST_SHIFT) |-> (dec_q ? (idx_q >= end_q) : (idx_q <= end_q)))
		else $error("shift index ran past its end");

endmodule

[rtl/shift_array_insert_delete_search.sv]
// Top level of the shift array with insert, delete, reverse and search.
// Usage:
//  - Requests arrive on the s_axis group; tuser carries the operation
//    (insert, delete, reverse, search), tdata the position and value.
//  - Every request gives one beat on the m_axis group: tuser is the found
//    flag, tdata the lowest matching slot (zero unless a search matched).
//  - One request is worked at a time; tready is low until it is finished.
//  - The entries sit in a one-read, one-write RAM; insert, delete and
//    search walk it one slot a cycle, while reverse reads both slots of
//    each pair and then writes them back swapped. An insert or delete at
//    the last slot skips the walk, and a delete beyond the array writes
//    nothing.
//  - A finished result waits in the output register; while it is held the
//    next request is still taken, and its own result waits until the
//    register frees.
//  - Reset empties the array (all entries read as zero) at once, with no
//    clearing pass, and drops any pending result.
module shift_array_insert_delete_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [2:0] position, [34:3] value, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [2:0] match_index, rest zero
	output logic        m_axis_tuser   // [0] found
);

	sai_pkg::req_t req;
	sai_pkg::res_t res, out_q;
	logic          idle, start, res_valid, res_ready, out_valid_q;

	assign req.op       = sai_pkg::op_t'(s_axis_tuser);
	assign req.position = s_axis_tdata[2:0];
	assign req.value    = s_axis_tdata[34:3];

	assign s_axis_tready = idle;
	assign start         = s_axis_tvalid && idle;
	assign res_ready     = !out_valid_q || m_axis_tready;

	sai_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.res_ready (res_ready),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.match_index};
	assign m_axis_tuser  = out_q.found;

endmodule

[tb/shift_array_insert_delete_search_tb.sv]
`timescale 1ns / 1ps
// Testbench for the shift array block: directed then random requests, results checked by a scoreboard.
module shift_array_insert_delete_search_tb;
	import sai_pkg::*;

	class array_scoreboard;
		logic signed [31:0] slots[ENTRIES];
		res_t               awaited[$];
		int                 errors;

		function new();
			foreach (slots[i]) slots[i] = '0;
			errors = 0;
		endfunction

		function void note_request(req_t r);
			res_t               res;
			int                 pos;
			logic signed [31:0] tmp;
			res = '0;
			pos = r.position;
			case (r.op)
			OP_INSERT: begin
				if (pos >= ENTRIES) begin
					slots[ENTRIES-1] = r.value;
				end else begin
					for (int i = ENTRIES - 1; i > pos; i--) slots[i] = slots[i-1];
					slots[pos] = r.value;
				end
			end
			OP_DELETE: begin
				if (pos < ENTRIES) begin
					for (int i = pos; i + 1 < ENTRIES; i++) slots[i] = slots[i+1];
					slots[ENTRIES-1] = '0;
				end
			end
			OP_REVERSE: begin
				for (int i = 0; i < ENTRIES / 2; i++) begin
					tmp                    = slots[i];
					slots[i]               = slots[ENTRIES-1-i];
					slots[ENTRIES-1-i]     = tmp;
				end
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slots[i] == r.value) begin
						res.found       = 1'b1;
						res.match_index = 3'(i);
						break;
					end
				end
			end
			endcase
			awaited.push_back(res);
		endfunction

		function void check_result(logic found, logic [2:0] idx);
			res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result beat with none awaited, found=%0b index=%0d",
					$time, found, idx);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (found !== want.found) begin
				$display("%0t: found mismatch, expected %0b actual %0b",
					$time, want.found, found);
				errors++;
			end
			if (idx !== want.match_index) begin
				$display("%0t: match_index mismatch, expected %0d actual %0d",
					$time, want.match_index, idx);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = OP_INSERT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;

	bit              steady = 1'b0;
	array_scoreboard sb = new();

	shift_array_insert_delete_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_request(op_t op, logic [2:0] pos, logic signed [31:0] v);
		req_t r;
		int   gap;
		r.op       = op;
		r.position = pos;
		r.value    = v;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, v, pos};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// values drawn from a small set so that duplicates and extremes recur
	function automatic logic signed [31:0] pool_value();
		case ($urandom_range(0, 5))
		0: return 32'sh0000_0000;
		1: return 32'shFFFF_FFFF;
		2: return 32'sh7FFF_FFFF;
		3: return 32'sh8000_0000;
		4: return 32'sh0000_0001;
		default: return 32'sh0000_0005;
		endcase
	endfunction

	// receive side
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tuser, m_axis_tdata[2:0]);
		end
	end

	initial begin
		int                 sel;
		op_t                op;
		logic signed [31:0] v;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats
		send_request(OP_SEARCH,  3'd0, 32'sh0000_0000);
		send_request(OP_SEARCH,  3'd5, 32'sh7FFF_FFFF);
		send_request(OP_INSERT,  3'd0, 32'sh7FFF_FFFF);
		send_request(OP_INSERT,  3'd7, 32'sh8000_0000);
		send_request(OP_INSERT,  3'd3, 32'shFFFF_FFFF);
		send_request(OP_INSERT,  3'd0, 32'sh1234_5678);
		send_request(OP_SEARCH,  3'd7, 32'sh8000_0000);
		send_request(OP_SEARCH,  3'd0, 32'shFFFF_FFFF);
		send_request(OP_DELETE,  3'd7, 32'sh0000_0000);
		send_request(OP_DELETE,  3'd0, 32'shFFFF_FFFF);
		send_request(OP_SEARCH,  3'd2, 32'sh7FFF_FFFF);
		send_request(OP_INSERT,  3'd1, 32'sh5555_5555);
		send_request(OP_INSERT,  3'd2, 32'shAAAA_AAAA);
		send_request(OP_REVERSE, 3'd7, 32'shFFFF_FFFF);
		send_request(OP_SEARCH,  3'd0, 32'sh5555_5555);
		send_request(OP_SEARCH,  3'd0, 32'sh0000_0000);
		send_request(OP_DELETE,  3'd3, 32'sh0000_0000);
		send_request(OP_REVERSE, 3'd0, 32'sh0000_0000);
		send_request(OP_INSERT,  3'd7, 32'sh0000_0000);
		send_request(OP_SEARCH,  3'd3, 32'sh0000_0000);
		send_request(OP_SEARCH,  3'd0, 32'sh1234_5678);
		drain();

		for (int n = 0; n < 450; n++) begin
			if (n % 40 == 0) steady = ($urandom_range(0, 2) == 0);
			if (n == 220) drain();
			sel = $urandom_range(0, 99);
			if (sel < 35) op = OP_INSERT;
			else if (sel < 55) op = OP_DELETE;
			else if (sel < 63) op = OP_REVERSE;
			else op = OP_SEARCH;
			case ($urandom_range(0, 3))
			0: v = pool_value();
			1: v = (op == OP_SEARCH) ? sb.slots[$urandom_range(0, ENTRIES - 1)] : $urandom;
			default: v = $urandom;
			endcase
			send_request(op, 3'($urandom_range(0, 7)), v);
		end
		steady = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
